### hdl/tqbpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqbpp_pkg: ticket queue shared definitions
// Command and status codes, item structs, sequencer states and the default queue depth.
// ----------------------------------------------------------------------------
package tqbpp_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 16;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REPORT = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] count;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [4:0]  occupancy;
        logic [31:0] ticket;
        logic        is_listing;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_DONE,
        S_REP_HDR,
        S_REP_LD
    } t_state;

endpackage

### hdl/tqbpp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqbpp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tqbpp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/ticket_queue_batch_push_pop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ticket_queue_batch_push_pop: ticket queue with batch push and pop
// Ring buffer of ticket numbers with a 32-bit ticket counter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) takes one command:
//   push a batch, pop a batch, or report. Output channel (o_out_valid /
//   i_out_ready / o_out_item) returns results; o_out_item.last marks the
//   final result of a command.
//   Push of N: the tickets that fit are written one per cycle (one RAM
//   write each), all dropped tickets are retired at once, then S_DONE
//   posts the result. Pop and the unused code: the item is taken in
//   S_IDLE and S_DONE posts the result. Report: header plus one entry
//   per cycle while the receiver is ready, set by the single RAM read port;
//   the read for the first entry is issued as the header is posted.
//   One command is in work at a time; o_in_ready is high only between
//   commands, and a new command is taken while the previous result still
//   sits in the output register.
//   Reset empties the queue and zeroes the ticket counter; stored tickets
//   are not cleared. A stalled receiver holds the output item, and the
//   sequencer waits in place in the states that post a result.
// ----------------------------------------------------------------------------
module ticket_queue_batch_push_pop
    import tqbpp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = ((CW > 8) ? CW : 8) + 1;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_fill, n_fill;
    logic [31:0]       r_ticket, n_ticket;
    logic [7:0]        r_rem, n_rem;
    logic              r_ovf, n_ovf;
    t_status           r_status, n_status;
    logic [AW-1:0]     r_rd_idx, n_rd_idx;
    logic [CW-1:0]     r_left, n_left;
    t_out_item         r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic              w_slot_free;
    logic              w_full;
    logic [31:0]       w_tick_sum;
    logic [CW+4:0]     w_fill_ext;
    logic [4:0]        w_occ;
    logic [PW-1:0]     w_pop_sum;
    logic [PW-1:0]     w_pop_wrap;
    logic              w_wr_en;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic [31:0]       w_rd_data;
    logic              w_accept;

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] idx);
        next_idx = (idx == AW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_full      = (r_fill == CW'(QUEUE_DEPTH));
    assign w_tick_sum  = r_ticket + (w_full ? 32'(r_rem) : 32'd1);
    assign w_fill_ext  = {5'b0, r_fill};
    assign w_occ       = w_fill_ext[4:0];
    assign w_pop_sum   = PW'(r_head) + PW'(i_in_item.count);
    assign w_pop_wrap  = (w_pop_sum >= PW'(QUEUE_DEPTH)) ? w_pop_sum - PW'(QUEUE_DEPTH)
                                                           : w_pop_sum;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_rd_addr   = (r_state == S_REP_HDR) ? r_head : r_rd_idx;

    tqbpp_ram #(
        .WIDTH (32),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (w_tick_sum),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_ticket    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_ticket    <= n_ticket;
            r_out_valid <= n_out_valid;
        end
        r_rem    <= n_rem;
        r_ovf    <= n_ovf;
        r_status <= n_status;
        r_rd_idx <= n_rd_idx;
        r_left   <= n_left;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_ticket    = r_ticket;
        n_rem       = r_rem;
        n_ovf       = r_ovf;
        n_status    = r_status;
        n_rd_idx    = r_rd_idx;
        n_left      = r_left;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        o_in_ready  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (w_accept) begin
                    case (i_in_item.command)
                        CMD_PUSH: begin
                            n_rem   = i_in_item.count;
                            n_ovf   = 1'b0;
                            n_state = S_PUSH;
                        end
                        CMD_POP: begin
                            if (PW'(i_in_item.count) > PW'(r_fill)) begin
                                n_fill   = '0;
                                n_head   = '0;
                                n_tail   = '0;
                                n_status = ST_UNDERFLOW;
                            end else begin
                                n_head   = w_pop_wrap[AW-1:0];
                                n_fill   = r_fill - CW'(i_in_item.count);
                                n_status = ST_OK;
                            end
                            n_state = S_DONE;
                        end
                        CMD_REPORT: begin
                            n_state = S_REP_HDR;
                        end
                        default: begin
                            n_status = ST_OK;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_PUSH: begin
                if (r_rem == 8'd0) begin
                    n_status = r_ovf ? ST_OVERFLOW : ST_OK;
                    n_state  = S_DONE;
                end else if (w_full) begin
                    n_ticket = w_tick_sum;
                    n_rem    = 8'd0;
                    n_ovf    = 1'b1;
                end else begin
                    w_wr_en  = 1'b1;
                    n_ticket = w_tick_sum;
                    n_tail   = next_idx(r_tail);
                    n_fill   = r_fill + 1'b1;
                    n_rem    = r_rem - 8'd1;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_out       = '{status: r_status, occupancy: w_occ, ticket: 32'd0,
                                    is_listing: 1'b0, last: 1'b1};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_REP_HDR: begin
                if (w_slot_free) begin
                    n_out       = '{status: ST_OK, occupancy: w_occ, ticket: 32'd0,
                                    is_listing: 1'b0, last: (r_fill == '0)};
                    n_out_valid = 1'b1;
                    if (r_fill == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        w_rd_en  = 1'b1;
                        n_rd_idx = next_idx(r_head);
                        n_left   = r_fill;
                        n_state  = S_REP_LD;
                    end
                end
            end
            S_REP_LD: begin
                if (w_slot_free) begin
                    n_out       = '{status: ST_OK, occupancy: w_occ, ticket: w_rd_data,
                                    is_listing: 1'b1, last: (r_left == CW'(1))};
                    n_out_valid = 1'b1;
                    n_left      = r_left - 1'b1;
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        w_rd_en  = 1'b1;
                        n_rd_idx = next_idx(r_rd_idx);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### hdl/tqbpp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqbpp_checker: port-level checks for the ticket queue
// Watches both channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module tqbpp_checker
    import tqbpp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_out_valid && !i_out_ready) |->
            o_out_valid && $stable(o_out_item))
        else $error("output item dropped or changed while stalled");

    a_busy_mid_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last |-> !o_in_ready)
        else $error("new command offered before the report ended");

    a_no_listing_ticket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.is_listing |-> o_out_item.ticket == 32'd0)
        else $error("nonzero ticket on a result without a listed item");

    a_listing_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.is_listing |-> o_out_item.status == ST_OK)
        else $error("listed item with bad status");

endmodule

bind ticket_queue_batch_push_pop tqbpp_checker u_tqbpp_checker (.*);
